/* hw/rtl/bptc_pkg.sv */
// Shared types and constants for the barometric pressure/temperature compensation block.
// Used by the top level and its checker; no dependencies.
`timescale 1ns / 1ps

package bptc_pkg;

   // Calibration register indexes
   localparam logic [2:0] RegC1Sens     = 3'd0;
   localparam logic [2:0] RegC2Offset   = 3'd1;
   localparam logic [2:0] RegC3Tcs      = 3'd2;
   localparam logic [2:0] RegC4Tco      = 3'd3;
   localparam logic [2:0] RegC5Tref     = 3'd4;
   localparam logic [2:0] RegC6Tempsens = 3'd5;

   // Temperature offset, hundredths of a degree (20.00 C)
   localparam logic signed [18:0] TempBase = 19'sd2000;

   // Result temperature bounds over all inputs and coefficients
   localparam int TempMin = -129070;
   localparam int TempMax = 133070;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_word_type;

   typedef struct packed {
      logic signed [18:0] temperature;
      logic signed [23:0] pressure;
   } rsp_word_type;

endpackage

/* hw/rtl/baro_pressure_temp_compensation_top.sv */
// First-order pressure/temperature compensation, six-stage pipeline.
// Depends on bptc_pkg.
`timescale 1ns / 1ps
//
//  channel   ports                                  handshake
//  request   start, req_word, busy                  taken when start && !busy
//  response  rsp_valid, rsp_word                    one-cycle strobe, no back-pressure
//  csr       csr_we, csr_index, csr_wdata           write when csr_we, no wait
//
// One word enters per cycle while busy is low; its response comes from rsp_ff.
// Depth is set by the chain dT, coefficient multiplies, OFF/SENS sums, the split
// D1 x SENS product, its 61-bit recombination and the final subtract and shift.
// busy is set in reset and cleared once reset drops. Reset clears the valid bits and
// the coefficients. The receiver cannot stall, so nothing in the pipeline ever waits.

module baro_pressure_temp_compensation_top
   import bptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_word_type req_word,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // Coefficients
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic        busy_ff;
   logic [5:0]  vld_ff;
   logic        accept;

   // Stage 1: dT and D1
   logic signed [24:0] dt_in, dt_ff;
   logic [23:0]        d1_s1_ff;
   // Stage 2: coefficient products
   logic signed [41:0] prod6_in, prod4_in, prod3_in;
   logic signed [41:0] prod6_ff, prod4_ff, prod3_ff;
   logic [23:0]        d1_s2_ff;
   // Stage 3: TEMP, OFF, SENS
   logic signed [18:0] temp_in, temp_s3_ff, temp_s4_ff, temp_s5_ff;
   logic signed [36:0] off_in, off_s3_ff, off_s4_ff, off_s5_ff;
   logic signed [35:0] sens_in, sens_ff;
   logic [23:0]        d1_s3_ff;
   // Stage 4: split D1 x SENS
   logic [41:0]        pp_lo_in, pp_lo_ff;
   logic signed [42:0] pp_hi_in, pp_hi_ff;
   // Stage 5: recombined product >> 21
   logic signed [60:0] full_sum;
   logic signed [39:0] ps_in, ps_ff;
   // Stage 6: result
   logic signed [40:0] diff;
   rsp_word_type       rsp_in, rsp_ff;

   assign accept = start && !busy_ff;

   // Control and coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
         c1_ff   <= '0;
         c2_ff   <= '0;
         c3_ff   <= '0;
         c4_ff   <= '0;
         c5_ff   <= '0;
         c6_ff   <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[4:0], accept};
         if (csr_we) begin
            case (csr_index)
               RegC1Sens:     c1_ff <= csr_wdata;
               RegC2Offset:   c2_ff <= csr_wdata;
               RegC3Tcs:      c3_ff <= csr_wdata;
               RegC4Tco:      c4_ff <= csr_wdata;
               RegC5Tref:     c5_ff <= csr_wdata;
               RegC6Tempsens: c6_ff <= csr_wdata;
               default:       ;
            endcase
         end
      end
   end

   // Stage 1: dT = D2 - C5 * 2^8
   assign dt_in = $signed({1'b0, req_word.raw_temperature}) - $signed({1'b0, c5_ff, 8'b0});

   // Stage 2: dT * C6, dT * C4, dT * C3
   assign prod6_in = dt_ff * $signed({1'b0, c6_ff});
   assign prod4_in = dt_ff * $signed({1'b0, c4_ff});
   assign prod3_in = dt_ff * $signed({1'b0, c3_ff});

   // Stage 3: arithmetic shifts by taking the upper bits, then the sums
   assign temp_in = prod6_ff[41:23] + TempBase;
   assign off_in  = {prod4_ff[41], prod4_ff[41:6]} + $signed({4'b0, c2_ff, 17'b0});
   assign sens_in = {prod3_ff[41], prod3_ff[41:7]} + $signed({4'b0, c1_ff, 16'b0});

   // Stage 4: D1 x SENS as an unsigned low and a signed high partial product
   assign pp_lo_in = d1_s3_ff * sens_ff[17:0];
   assign pp_hi_in = $signed({1'b0, d1_s3_ff}) * $signed(sens_ff[35:18]);

   // Stage 5: recombine and shift right by 21
   assign full_sum = $signed({pp_hi_ff, 18'b0}) + $signed({19'b0, pp_lo_ff});
   assign ps_in    = full_sum[60:21];

   // Stage 6: (product - OFF) >> 15
   assign diff = {ps_ff[39], ps_ff} - {{4{off_s5_ff[36]}}, off_s5_ff};
   always_comb begin
      rsp_in.temperature = temp_s5_ff;
      rsp_in.pressure    = diff[38:15];
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      dt_ff      <= dt_in;
      d1_s1_ff   <= req_word.raw_pressure;
      prod6_ff   <= prod6_in;
      prod4_ff   <= prod4_in;
      prod3_ff   <= prod3_in;
      d1_s2_ff   <= d1_s1_ff;
      temp_s3_ff <= temp_in;
      off_s3_ff  <= off_in;
      sens_ff    <= sens_in;
      d1_s3_ff   <= d1_s2_ff;
      pp_lo_ff   <= pp_lo_in;
      pp_hi_ff   <= pp_hi_in;
      temp_s4_ff <= temp_s3_ff;
      off_s4_ff  <= off_s3_ff;
      ps_ff      <= ps_in;
      temp_s5_ff <= temp_s4_ff;
      off_s5_ff  <= off_s4_ff;
      rsp_ff     <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = vld_ff[5];
   assign rsp_word  = rsp_ff;

endmodule

/* hw/rtl/baro_pressure_temp_compensation_chk.sv */
// Port-level checker for the compensation block, bound to the top level.
// Depends on bptc_pkg and baro_pressure_temp_compensation_top.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_chk
   import bptc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);

   // Every taken word gives a response once it has passed the pipeline stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("taken word gave no response after six cycles");

   // No response without a word taken into the pipeline before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("response without a matching request");

   // busy is high in the cycle after reset is sampled high
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_busy_clear: assert property (@(posedge clock) !reset |=> !busy)
      else $error("busy high outside reset");

   // Temperature stays in its bounded range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.temperature >= TempMin) && (rsp_word.temperature <= TempMax))
      else $error("temperature out of range");

endmodule

bind baro_pressure_temp_compensation_top baro_pressure_temp_compensation_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
